@@ sv/dls_pkg.sv @@
// ----------------------------------------------------------------------------
// dls_pkg
// Shared types, codes and constants of the dense layer with sigmoid output,
// plus the elaboration-time builder of the sigmoid table.
// ----------------------------------------------------------------------------
package dls_pkg;

   localparam int DATA_BITS       = 16;
   localparam int FRAC_BITS       = 12;
   localparam int ACC_FRAC        = 24;
   localparam int SIGMOID_ENTRIES = 256;
   localparam int SIG_IDX_BITS    = $clog2(SIGMOID_ENTRIES);
   localparam int SIG_SHIFT       = ACC_FRAC + 4 - SIG_IDX_BITS;
   localparam int CFG_W           = 7;
   localparam int NEURON_W        = 6;
   localparam int SEL_W           = 6;
   localparam int ACT_W           = 16;
   localparam int CSR_IDX_W       = 1;

   // Q4.12 one, used as the second operand when the bias goes through the mac
   localparam logic signed [DATA_BITS-1:0] ONE_Q = DATA_BITS'(1 << FRAC_BITS);

   localparam logic [1:0] CMD_WEIGHT = 2'd0;
   localparam logic [1:0] CMD_BIAS   = 2'd1;
   localparam logic [1:0] CMD_INPUT  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_INPUTS  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_NEURONS = 1'd1;

   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   localparam logic [63:0] Q62_ONE = 64'd1 << 62;
   localparam logic [63:0] Q40_ONE = 64'd1 << 40;

   typedef struct packed {
      logic [1:0]                  cmd;
      logic [SEL_W-1:0]            neuron_sel;
      logic [SEL_W-1:0]            input_sel;
      logic signed [DATA_BITS-1:0] value;
      logic                        last;
   } req_type;

   typedef struct packed {
      logic [NEURON_W-1:0] neuron_out;
      logic [ACT_W-1:0]    activation;
      logic                size_error;
      logic                end_of_run;
   } rsp_type;

   typedef struct packed {
      logic                first;
      logic                last_step;
      logic                end_run;
      logic [NEURON_W-1:0] neuron;
   } mac_tag_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // restoring division, floor(num / den)
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem  = rem - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // (a * b) >> 62, low 64 bits
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // floor(num * 2^62 / den) for num below den
   function automatic logic [63:0] frac_q62(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] rem;
      q   = '0;
      rem = num;
      for (int i = 0; i < 62; i++) begin
         rem = rem << 1;
         q   = q << 1;
         if (rem >= den) begin
            rem  = rem - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   // one table entry: round(65535 / (1 + exp(-x))) at the cell center
   function automatic logic [ACT_W-1:0] sig_entry(input int k);
      longint      n;
      logic        neg;
      logic [63:0] an;
      logic [63:0] r;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] u;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] q;
      n    = 64'(16 * k + 8) - 64'(8 * SIGMOID_ENTRIES);
      neg  = n < 0;
      an   = neg ? 64'(-n) : 64'(n);
      r    = frac_q62(an, 64'(16 * SIGMOID_ENTRIES));
      term = Q62_ONE;
      sum  = Q62_ONE;
      for (int i = 1; i < 48; i++) begin
         term = udiv64(mul_q62(term, r), 64'(i));
         if ((i % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      for (int i = 0; i < 4; i++) begin
         sum = mul_q62(sum, sum);
      end
      u   = sum >> 22;
      num = neg ? (64'd65535 * u) : (64'd65535 << 40);
      den = Q40_ONE + u;
      q   = udiv64(2 * num + den, 2 * den);
      return q[ACT_W-1:0];
   endfunction

endpackage

@@ sv/dls_mem.sv @@
// ----------------------------------------------------------------------------
// dls_mem
// Weight, bias and input vector stores: one write and one registered read
// port each.
// ----------------------------------------------------------------------------
module dls_mem #(
   parameter int MAX_INPUTS  = 64,
   parameter int MAX_NEURONS = 64,
   localparam int WDEPTH = MAX_NEURONS * MAX_INPUTS,
   localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1,
   localparam int NIDX_W = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1,
   localparam int IIDX_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1
) (
   input  logic                                  clock,
   input  logic                                  w_we,
   input  logic [WA_W-1:0]                       w_waddr,
   input  logic                                  b_we,
   input  logic [NIDX_W-1:0]                     b_waddr,
   input  logic                                  x_we,
   input  logic [IIDX_W-1:0]                     x_waddr,
   input  logic signed [dls_pkg::DATA_BITS-1:0]  wr_value,
   input  logic [WA_W-1:0]                       w_raddr,
   input  logic [NIDX_W-1:0]                     b_raddr,
   input  logic [IIDX_W-1:0]                     x_raddr,
   output logic signed [dls_pkg::DATA_BITS-1:0]  w_rdata,
   output logic signed [dls_pkg::DATA_BITS-1:0]  b_rdata,
   output logic signed [dls_pkg::DATA_BITS-1:0]  x_rdata
);

   logic signed [dls_pkg::DATA_BITS-1:0] weight_mem [WDEPTH];
   logic signed [dls_pkg::DATA_BITS-1:0] bias_mem   [MAX_NEURONS];
   logic signed [dls_pkg::DATA_BITS-1:0] input_mem  [MAX_INPUTS];

   always_ff @(posedge clock) begin
      if (w_we) begin
         weight_mem[w_waddr] <= wr_value;
      end
      w_rdata <= weight_mem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         bias_mem[b_waddr] <= wr_value;
      end
      b_rdata <= bias_mem[b_raddr];
   end

   always_ff @(posedge clock) begin
      if (x_we) begin
         input_mem[x_waddr] <= wr_value;
      end
      x_rdata <= input_mem[x_raddr];
   end

endmodule

@@ sv/dls_mac.sv @@
// ----------------------------------------------------------------------------
// dls_mac
// Shared multiply-accumulate unit: registered 16x16 product, then a wide
// accumulator that restarts on the bias step of each neuron.
// ----------------------------------------------------------------------------
module dls_mac #(
   parameter int ACC_W = 40
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  op_valid,
   input  dls_pkg::mac_tag_type                  op_tag,
   input  logic signed [dls_pkg::DATA_BITS-1:0]  bias_word,
   input  logic signed [dls_pkg::DATA_BITS-1:0]  weight_word,
   input  logic signed [dls_pkg::DATA_BITS-1:0]  input_word,
   output logic                                  acc_valid,
   output dls_pkg::mac_tag_type                  acc_tag,
   output logic signed [ACC_W-1:0]               acc_value
);

   localparam int PROD_W = 2 * dls_pkg::DATA_BITS;

   logic signed [dls_pkg::DATA_BITS-1:0] opa;
   logic signed [dls_pkg::DATA_BITS-1:0] opb;
   logic signed [PROD_W-1:0]             prod_in;
   logic signed [PROD_W-1:0]             prod_ff;
   logic                                 pvalid_ff;
   dls_pkg::mac_tag_type                 ptag_ff;
   logic signed [ACC_W-1:0]              prod_ext;
   logic signed [ACC_W-1:0]              acc_in;
   logic signed [ACC_W-1:0]              acc_ff;
   logic                                 avalid_ff;
   dls_pkg::mac_tag_type                 atag_ff;

   // bias step multiplies the bias by one in q4.12
   assign opa     = op_tag.first ? bias_word : weight_word;
   assign opb     = op_tag.first ? dls_pkg::ONE_Q : input_word;
   assign prod_in = opa * opb;

   assign prod_ext = ACC_W'(prod_ff);
   assign acc_in   = ptag_ff.first ? prod_ext : acc_ff + prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         avalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= op_valid;
         avalid_ff <= pvalid_ff && ptag_ff.last_step;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      ptag_ff <= op_tag;
      if (pvalid_ff) begin
         acc_ff  <= acc_in;
         atag_ff <= ptag_ff;
      end
   end

   assign acc_valid = avalid_ff;
   assign acc_tag   = atag_ff;
   assign acc_value = acc_ff;

endmodule

@@ sv/dls_sigmoid.sv @@
// ----------------------------------------------------------------------------
// dls_sigmoid
// Clamps the q16.24 sum to [-8,8), forms the table index, then reads the
// sigmoid table into a register.
// ----------------------------------------------------------------------------
module dls_sigmoid #(
   parameter int ACC_W = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          acc_valid,
   input  dls_pkg::mac_tag_type          acc_tag,
   input  logic signed [ACC_W-1:0]       acc_value,
   output logic                          sig_valid,
   output dls_pkg::mac_tag_type          sig_tag,
   output logic [dls_pkg::ACT_W-1:0]     sig_act
);

   localparam int IDX_W = dls_pkg::SIG_IDX_BITS;
   localparam int TOP   = dls_pkg::ACC_FRAC + 3;
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd1 <<< TOP);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI;

   logic [dls_pkg::ACT_W-1:0] rom [dls_pkg::SIGMOID_ENTRIES];

   for (genvar k = 0; k < dls_pkg::SIGMOID_ENTRIES; k++) begin : g_rom
      localparam logic [dls_pkg::ACT_W-1:0] ENTRY = dls_pkg::sig_entry(k);
      assign rom[k] = ENTRY;
   end

   logic [ACC_W-1:0]          offset;
   logic [IDX_W-1:0]          idx_in;
   logic [IDX_W-1:0]          idx_ff;
   logic                      v1_ff;
   dls_pkg::mac_tag_type      tag1_ff;
   logic                      v2_ff;
   dls_pkg::mac_tag_type      tag2_ff;
   logic [dls_pkg::ACT_W-1:0] act_ff;

   assign offset = ACC_W'(acc_value - SAT_LO);

   always_comb begin
      if (acc_value < SAT_LO) begin
         idx_in = '0;
      end else if (acc_value >= SAT_HI) begin
         idx_in = '1;
      end else begin
         idx_in = offset[TOP -: IDX_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= acc_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      tag1_ff <= acc_tag;
      act_ff  <= rom[idx_ff];
      tag2_ff <= tag1_ff;
   end

   assign sig_valid = v2_ff;
   assign sig_tag   = tag2_ff;
   assign sig_act   = act_ff;

endmodule

@@ sv/dense_layer_sigmoid.sv @@
// ----------------------------------------------------------------------------
// dense_layer_sigmoid
// Fully connected layer on signed q4.12 data with sigmoid activation, one shared
// multiply-accumulate unit stepped by a small sequencer.
// ----------------------------------------------------------------------------
// Weight loads, bias loads and input elements are taken one per cycle while
// busy is low. The element flagged last starts the layer pass, if at least one
// neuron is set, unless its count differs from num_inputs, in which case a
// single error transaction appears in the next cycle and busy stays low. A pass
// runs every used neuron through the one 16x16 mac, one product per cycle: a
// bias step then one step per input. busy stays high from the cycle after the
// last element until the final result is on the outputs. Results are one-cycle
// strobes on rsp_valid and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module dense_layer_sigmoid #(
   parameter int MAX_INPUTS  = 64,
   parameter int MAX_NEURONS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  dls_pkg::req_type                req_data,
   output logic                            rsp_valid,
   output dls_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [dls_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dls_pkg::CFG_W-1:0]       csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_INPUTS + 1);
   localparam int IIDX_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int NIDX_W = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
   localparam int WDEPTH = MAX_NEURONS * MAX_INPUTS;
   localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int ICMP_W = (CNT_W > dls_pkg::CFG_W) ? CNT_W : dls_pkg::CFG_W;
   localparam int NCNT_W = $clog2(MAX_NEURONS + 1);
   localparam int NCMP_W = (NCNT_W > dls_pkg::CFG_W) ? NCNT_W : dls_pkg::CFG_W;
   localparam int ACC_W  = 2 * dls_pkg::DATA_BITS + CNT_W + 1;

   // configuration
   logic [dls_pkg::CFG_W-1:0] num_inputs_ff;
   logic [dls_pkg::CFG_W-1:0] num_neurons_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_inputs_ff  <= dls_pkg::CFG_RESET;
         num_neurons_ff <= dls_pkg::CFG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            dls_pkg::CSR_NUM_INPUTS:  num_inputs_ff  <= csr_wdata;
            dls_pkg::CSR_NUM_NEURONS: num_neurons_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // command decode
   logic accept;
   logic load_w;
   logic load_b;
   logic is_elem;
   logic vec_end;
   logic size_bad;
   logic run_go;
   logic err_go;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] count_next;
   logic             count_full;
   logic             ovf_ff;
   logic             ovf_in;
   logic             ovf_next;

   logic [NCMP_W-1:0] neurons_cfg;
   logic [NCMP_W-1:0] neurons;
   logic [NCMP_W-1:0] nlast;
   logic [WA_W-1:0]   load_waddr;

   assign accept  = start && !busy;
   assign load_w  = accept && (req_data.cmd == dls_pkg::CMD_WEIGHT) &&
                    (int'(req_data.neuron_sel) < MAX_NEURONS) &&
                    (int'(req_data.input_sel) < MAX_INPUTS);
   assign load_b  = accept && (req_data.cmd == dls_pkg::CMD_BIAS) &&
                    (int'(req_data.neuron_sel) < MAX_NEURONS);
   assign is_elem = accept && (req_data.cmd == dls_pkg::CMD_INPUT);
   assign vec_end = is_elem && req_data.last;

   assign load_waddr = WA_W'(int'(req_data.neuron_sel) * MAX_INPUTS +
                             int'(req_data.input_sel));

   assign count_full = (count_ff == CNT_W'(MAX_INPUTS));
   assign count_next = count_full ? count_ff : count_ff + CNT_W'(1);
   assign ovf_next   = ovf_ff || count_full;
   assign size_bad   = ovf_next || (ICMP_W'(count_next) != ICMP_W'(num_inputs_ff));

   assign neurons_cfg = NCMP_W'(num_neurons_ff);
   assign neurons     = (neurons_cfg > NCMP_W'(MAX_NEURONS)) ? NCMP_W'(MAX_NEURONS)
                                                            : neurons_cfg;
   assign nlast       = neurons - NCMP_W'(1);

   assign run_go = vec_end && !size_bad && (neurons != '0);
   assign err_go = vec_end && size_bad;

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (vec_end) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (is_elem) begin
         count_in = count_next;
         ovf_in   = ovf_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // sequencer
   dls_pkg::state_type state_ff;
   dls_pkg::state_type state_in;
   logic               issue;
   logic               sig_valid;
   dls_pkg::mac_tag_type sig_tag;
   logic [dls_pkg::ACT_W-1:0] sig_act;

   logic [CNT_W-1:0]  run_len_ff;
   logic [CNT_W-1:0]  s_ff;
   logic [CNT_W-1:0]  s_in;
   logic [NCMP_W-1:0] j_ff;
   logic [NCMP_W-1:0] j_in;
   logic [WA_W-1:0]   base_ff;
   logic [WA_W-1:0]   base_in;
   logic              step_last;
   logic              pass_last;
   logic [CNT_W-1:0]  step_idx;

   assign step_last = (s_ff == run_len_ff);
   assign pass_last = step_last && (j_ff == nlast);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dls_pkg::ST_IDLE:  if (run_go) state_in = dls_pkg::ST_RUN;
         dls_pkg::ST_RUN:   if (pass_last) state_in = dls_pkg::ST_DRAIN;
         dls_pkg::ST_DRAIN: if (sig_valid && sig_tag.end_run) state_in = dls_pkg::ST_IDLE;
         default:           state_in = dls_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy  = 1'b1;
      issue = 1'b0;
      case (state_ff)
         dls_pkg::ST_IDLE:  busy  = 1'b0;
         dls_pkg::ST_RUN:   issue = 1'b1;
         dls_pkg::ST_DRAIN: issue = 1'b0;
         default:           busy  = 1'b0;
      endcase
   end

   always_comb begin
      s_in    = s_ff;
      j_in    = j_ff;
      base_in = base_ff;
      if (!busy) begin
         s_in    = '0;
         j_in    = '0;
         base_in = '0;
      end else if (issue) begin
         if (step_last) begin
            s_in    = '0;
            j_in    = j_ff + NCMP_W'(1);
            base_in = base_ff + WA_W'(MAX_INPUTS);
         end else begin
            s_in = s_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dls_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff    <= s_in;
      j_ff    <= j_in;
      base_ff <= base_in;
      if (vec_end) begin
         run_len_ff <= count_next;
      end
   end

   // issue: step zero reads the bias, step s reads input s-1 and its weight
   dls_pkg::mac_tag_type iss_tag;
   dls_pkg::mac_tag_type iss_tag_ff;
   logic                 iss_valid_ff;

   assign step_idx = (s_ff == '0) ? '0 : s_ff - CNT_W'(1);

   assign iss_tag.first     = (s_ff == '0);
   assign iss_tag.last_step = step_last;
   assign iss_tag.end_run   = pass_last;
   assign iss_tag.neuron    = dls_pkg::NEURON_W'(j_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_valid_ff <= 1'b0;
      end else begin
         iss_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      iss_tag_ff <= iss_tag;
   end

   logic signed [dls_pkg::DATA_BITS-1:0] w_rdata;
   logic signed [dls_pkg::DATA_BITS-1:0] b_rdata;
   logic signed [dls_pkg::DATA_BITS-1:0] x_rdata;

   dls_mem #(
      .MAX_INPUTS  (MAX_INPUTS),
      .MAX_NEURONS (MAX_NEURONS)
   ) u_mem (
      .clock    (clock),
      .w_we     (load_w),
      .w_waddr  (load_waddr),
      .b_we     (load_b),
      .b_waddr  (NIDX_W'(req_data.neuron_sel)),
      .x_we     (is_elem && !count_full),
      .x_waddr  (count_ff[IIDX_W-1:0]),
      .wr_value (req_data.value),
      .w_raddr  (base_ff + WA_W'(step_idx)),
      .b_raddr  (j_ff[NIDX_W-1:0]),
      .x_raddr  (step_idx[IIDX_W-1:0]),
      .w_rdata  (w_rdata),
      .b_rdata  (b_rdata),
      .x_rdata  (x_rdata)
   );

   logic                    acc_valid;
   dls_pkg::mac_tag_type    acc_tag;
   logic signed [ACC_W-1:0] acc_value;

   dls_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (iss_valid_ff),
      .op_tag      (iss_tag_ff),
      .bias_word   (b_rdata),
      .weight_word (w_rdata),
      .input_word  (x_rdata),
      .acc_valid   (acc_valid),
      .acc_tag     (acc_tag),
      .acc_value   (acc_value)
   );

   dls_sigmoid #(
      .ACC_W (ACC_W)
   ) u_sigmoid (
      .clock     (clock),
      .reset     (reset),
      .acc_valid (acc_valid),
      .acc_tag   (acc_tag),
      .acc_value (acc_value),
      .sig_valid (sig_valid),
      .sig_tag   (sig_tag),
      .sig_act   (sig_act)
   );

   // result register
   logic             rsp_valid_ff;
   dls_pkg::rsp_type rsp_ff;
   dls_pkg::rsp_type rsp_in;

   always_comb begin
      if (err_go) begin
         rsp_in.neuron_out = '0;
         rsp_in.activation = '0;
         rsp_in.size_error = 1'b1;
         rsp_in.end_of_run = 1'b1;
      end else begin
         rsp_in.neuron_out = sig_tag.neuron;
         rsp_in.activation = sig_act;
         rsp_in.size_error = 1'b0;
         rsp_in.end_of_run = sig_tag.end_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= err_go || sig_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_sig_only_busy: assert property (@(posedge clock) disable iff (reset)
      sig_valid |-> busy)
      else $error("activation produced while idle");

   a_run_counters: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dls_pkg::ST_RUN) |-> (s_ff <= run_len_ff) && (j_ff <= nlast))
      else $error("sequencer counters out of range");

   a_end_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.end_of_run && !rsp_ff.size_error) |-> !busy)
      else $error("busy still set after final transaction");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_INPUTS))
      else $error("element count past buffer depth");

endmodule

@@ dv/dense_layer_sigmoid_checker.sv @@
// ----------------------------------------------------------------------------
// dense_layer_sigmoid_checker
// Watches the request, result and register ports of the dense layer, keeps
// its own copy of the weight, bias and input stores and of the layer settings,
// predicts every sigmoid result when a vector closes and compares each result
// transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module dense_layer_sigmoid_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  dls_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  dls_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [dls_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dls_pkg::CFG_W-1:0]     csr_wdata,
   output int                            mismatches,
   output int                            pending,
   output int                            results_checked,
   output int                            size_errors_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     LAYER_INPUTS  = 64;
   localparam int     LAYER_NEURONS = 64;
   localparam longint SUM_LOW       = -(longint'(8) << dls_pkg::ACC_FRAC);
   localparam longint SUM_HIGH      = longint'(8) << dls_pkg::ACC_FRAC;
   localparam int     STEP_SHIFT    = 62 - 4 - dls_pkg::SIG_IDX_BITS;

   logic signed [dls_pkg::DATA_BITS-1:0] weight_mem [LAYER_NEURONS][LAYER_INPUTS];
   logic signed [dls_pkg::DATA_BITS-1:0] bias_mem [LAYER_NEURONS];
   logic signed [dls_pkg::DATA_BITS-1:0] vector_buf [LAYER_INPUTS];
   logic [dls_pkg::ACT_W-1:0]            sig_lut [dls_pkg::SIGMOID_ENTRIES];
   int unsigned                          vector_len;
   logic                                 vector_overrun;
   logic [dls_pkg::CFG_W-1:0]            inputs_cfg;
   logic [dls_pkg::CFG_W-1:0]            neurons_cfg;
   dls_pkg::rsp_type                     activation_q[$];
   dls_pkg::rsp_type                     want;
   longint                               acc;
   int                                   neuron_count;
   int                                   lut_idx;

   function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] wide;
      wide = 128'(a) * 128'(b);
      return 64'(wide >> 62);
   endfunction

   task automatic check_field(input string field, input logic [31:0] expected,
                              input logic [31:0] actual);
      if (expected !== actual) begin
         mismatches++;
         $error("%s: expected %0d, got %0d", field, expected, actual);
      end
   endtask

   // sigmoid table at cell centers, exp(-|x|) from a series at |x|/16 squared four times
   initial begin
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] step;
      logic [63:0] u;
      logic [63:0] num;
      logic [63:0] den;
      logic        neg;
      longint      n;
      for (int k = 0; k < dls_pkg::SIGMOID_ENTRIES; k++) begin
         n    = 16 * k + 8 - 8 * dls_pkg::SIGMOID_ENTRIES;
         neg  = n < 0;
         step = (neg ? 64'(-n) : 64'(n)) << STEP_SHIFT;
         term = dls_pkg::Q62_ONE;
         sum  = dls_pkg::Q62_ONE;
         for (int i = 1; i < 48; i++) begin
            term = q62_mul(term, step) / 64'(i);
            if (i % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         repeat (4) sum = q62_mul(sum, sum);
         u   = sum >> 22;
         num = neg ? 64'd65535 * u : 64'd65535 << 40;
         den = dls_pkg::Q40_ONE + u;
         sig_lut[k] = dls_pkg::ACT_W'((2 * num + den) / (2 * den));
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         mismatches       = 0;
         results_checked  = 0;
         size_errors_seen = 0;
         vector_len       = 0;
         vector_overrun   = 1'b0;
         inputs_cfg       = dls_pkg::CFG_RESET;
         neurons_cfg      = dls_pkg::CFG_RESET;
         activation_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == dls_pkg::CSR_NUM_INPUTS) begin
               inputs_cfg = csr_wdata;
            end else if (csr_index == dls_pkg::CSR_NUM_NEURONS) begin
               neurons_cfg = csr_wdata;
            end
         end
         if (start && !busy) begin
            case (req_data.cmd)
               dls_pkg::CMD_WEIGHT: begin
                  weight_mem[req_data.neuron_sel][req_data.input_sel] = req_data.value;
               end
               dls_pkg::CMD_BIAS: begin
                  bias_mem[req_data.neuron_sel] = req_data.value;
               end
               dls_pkg::CMD_INPUT: begin
                  if (vector_len < LAYER_INPUTS) begin
                     vector_buf[vector_len] = req_data.value;
                     vector_len++;
                  end else begin
                     vector_overrun = 1'b1;
                  end
                  if (req_data.last) begin
                     if (vector_overrun || vector_len != inputs_cfg) begin
                        want.neuron_out = '0;
                        want.activation = '0;
                        want.size_error = 1'b1;
                        want.end_of_run = 1'b1;
                        activation_q = {activation_q, want};
                     end else begin
                        neuron_count = (neurons_cfg > LAYER_NEURONS) ? LAYER_NEURONS
                                                                      : int'(neurons_cfg);
                        for (int j = 0; j < neuron_count; j++) begin
                           acc = longint'(bias_mem[j]) * (longint'(1) << dls_pkg::FRAC_BITS);
                           for (int i = 0; i < vector_len; i++) begin
                              acc += longint'(vector_buf[i]) * longint'(weight_mem[j][i]);
                           end
                           if (acc < SUM_LOW) begin
                              lut_idx = 0;
                           end else if (acc >= SUM_HIGH) begin
                              lut_idx = dls_pkg::SIGMOID_ENTRIES - 1;
                           end else begin
                              lut_idx = int'((acc - SUM_LOW) >>> dls_pkg::SIG_SHIFT);
                           end
                           want.neuron_out = dls_pkg::NEURON_W'(j);
                           want.activation = sig_lut[lut_idx];
                           want.size_error = 1'b0;
                           want.end_of_run = (j == neuron_count - 1);
                           activation_q = {activation_q, want};
                        end
                     end
                     vector_len     = 0;
                     vector_overrun = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid) begin
            if (activation_q.size() == 0) begin
               mismatches++;
               $error("result transaction for neuron %0d with none expected",
                      rsp_data.neuron_out);
            end else begin
               want = activation_q.pop_front();
               check_field("neuron_out", want.neuron_out, rsp_data.neuron_out);
               check_field("activation", want.activation, rsp_data.activation);
               check_field("size_error", want.size_error, rsp_data.size_error);
               check_field("end_of_run", want.end_of_run, rsp_data.end_of_run);
               results_checked++;
               if (want.size_error) begin
                  size_errors_seen++;
               end
            end
         end
      end
      pending = activation_q.size();
   end

endmodule

@@ dv/dense_layer_sigmoid_tb.sv @@
// ----------------------------------------------------------------------------
// dense_layer_sigmoid_tb
// Drives weight and bias loads, ignored commands and input vectors of good,
// short, long and overflowing length into the dense layer over a range of
// layer settings, with random gaps, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module dense_layer_sigmoid_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_IGNORED  = 2'd3;
   localparam int         ITEM_TARGET  = 330;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   dls_pkg::req_type              req_data;
   logic                          rsp_valid;
   dls_pkg::rsp_type              rsp_data;
   logic                          csr_we;
   logic [dls_pkg::CSR_IDX_W-1:0] csr_index;
   logic [dls_pkg::CFG_W-1:0]     csr_wdata;
   int                            mismatches;
   int                            pending;
   int                            results_checked;
   int                            size_errors_seen;

   bit weight_written [64][64];
   bit bias_written [64];
   bit no_gaps;
   int items_sent;
   int vectors_sent;
   int settings_used;

   dense_layer_sigmoid dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dense_layer_sigmoid_checker chk (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .pending          (pending),
      .results_checked  (results_checked),
      .size_errors_seen (size_errors_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("Mismatches found");
      $finish;
   end

   // mostly values within [-1, 1) so sums land inside the table, sometimes full range
   function automatic logic signed [dls_pkg::DATA_BITS-1:0] draw_value();
      if ($urandom_range(0, 3) == 0) begin
         return dls_pkg::DATA_BITS'($urandom);
      end
      return dls_pkg::DATA_BITS'($urandom_range(0, 8191)) - dls_pkg::DATA_BITS'(4096);
   endfunction

   task automatic issue(input dls_pkg::req_type item);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      if (item.cmd != CMD_IGNORED) begin
         items_sent++;
      end
   endtask

   task automatic load_weight(input int j, input int i,
                              input logic signed [dls_pkg::DATA_BITS-1:0] v,
                              input logic last_flag);
      dls_pkg::req_type item;
      item.cmd        = dls_pkg::CMD_WEIGHT;
      item.neuron_sel = dls_pkg::SEL_W'(j);
      item.input_sel  = dls_pkg::SEL_W'(i);
      item.value      = v;
      item.last       = last_flag;
      weight_written[j][i] = 1'b1;
      issue(item);
   endtask

   task automatic load_bias(input int j, input logic signed [dls_pkg::DATA_BITS-1:0] v,
                            input logic last_flag);
      dls_pkg::req_type item;
      item.cmd        = dls_pkg::CMD_BIAS;
      item.neuron_sel = dls_pkg::SEL_W'(j);
      item.input_sel  = dls_pkg::SEL_W'($urandom);
      item.value      = v;
      item.last       = last_flag;
      bias_written[j] = 1'b1;
      issue(item);
   endtask

   task automatic element(input logic signed [dls_pkg::DATA_BITS-1:0] v,
                          input logic last_flag);
      dls_pkg::req_type item;
      item.cmd        = dls_pkg::CMD_INPUT;
      item.neuron_sel = dls_pkg::SEL_W'($urandom);
      item.input_sel  = dls_pkg::SEL_W'($urandom);
      item.value      = v;
      item.last       = last_flag;
      issue(item);
   endtask

   task automatic send_ignored();
      dls_pkg::req_type item;
      item.cmd        = CMD_IGNORED;
      item.neuron_sel = dls_pkg::SEL_W'($urandom);
      item.input_sel  = dls_pkg::SEL_W'($urandom);
      item.value      = dls_pkg::DATA_BITS'($urandom);
      item.last       = 1'($urandom);
      issue(item);
   endtask

   task automatic send_noise();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         load_weight($urandom_range(0, 63), $urandom_range(0, 63), draw_value(), 1'($urandom));
      end else if (pick < 8) begin
         load_bias($urandom_range(0, 63), draw_value(), 1'($urandom));
      end else begin
         send_ignored();
      end
   endtask

   task automatic send_vector(input int len);
      for (int e = 0; e < len; e++) begin
         if ($urandom_range(0, 5) == 0) begin
            send_noise();
         end
         element(draw_value(), e == len - 1);
      end
      vectors_sent++;
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0 || busy);
      repeat (16) @(posedge clock);
   endtask

   task automatic configure(input int n_in, input int n_neu);
      csr_we    <= 1'b1;
      csr_index <= dls_pkg::CSR_NUM_INPUTS;
      csr_wdata <= dls_pkg::CFG_W'(n_in);
      @(posedge clock);
      csr_index <= dls_pkg::CSR_NUM_NEURONS;
      csr_wdata <= dls_pkg::CFG_W'(n_neu);
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic run_phase(input int n_in, input int n_neu, input int n_vectors);
      int used;
      int len;
      settle();
      configure(n_in, n_neu);
      no_gaps = ($urandom_range(0, 3) == 0);
      used    = (n_neu > 64) ? 64 : n_neu;
      if (n_in >= 1 && n_in <= 64) begin
         for (int j = 0; j < used; j++) begin
            if (!bias_written[j]) begin
               load_bias(j, draw_value(), 1'($urandom));
            end
            for (int i = 0; i < n_in; i++) begin
               if (!weight_written[j][i]) begin
                  load_weight(j, i, draw_value(), 1'($urandom));
               end
            end
         end
      end
      for (int v = 0; v < n_vectors; v++) begin
         if (n_in < 1 || n_in > 64) begin
            send_vector($urandom_range(1, 6));
         end else if ($urandom_range(0, 4) == 0) begin
            do len = $urandom_range(1, (n_in + 3 > 64) ? 64 : n_in + 3); while (len == n_in);
            send_vector(len);
         end else begin
            send_vector(n_in);
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      no_gaps       = 1'b0;
      items_sent    = 0;
      vectors_sent  = 0;
      settings_used = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // full-scale sums, the exact lower clamp, ignored last flags
      configure(2, 2);
      load_bias(0, 16'sh7fff, 1'b1);
      load_bias(1, 16'sh8000, 1'b0);
      load_weight(0, 0, 16'sh7fff, 1'b1);
      load_weight(0, 1, 16'sh8000, 1'b0);
      load_weight(1, 0, 16'sh0000, 1'b0);
      load_weight(1, 1, 16'sh0000, 1'b1);
      load_weight(63, 63, 16'shffff, 1'b1);
      load_bias(63, 16'sh0001, 1'b1);
      send_ignored();
      element(16'sh7fff, 1'b0);
      element(16'sh8000, 1'b1);
      element(16'sh0000, 1'b1);
      element(16'sh0001, 1'b0);
      element(16'sh0002, 1'b0);
      element(16'sh0003, 1'b1);
      vectors_sent += 3;
      // middle of the table
      load_bias(0, 16'sh0000, 1'b0);
      load_bias(1, 16'sh0800, 1'b0);
      element(16'sh0000, 1'b0);
      element(16'sh0000, 1'b1);
      vectors_sent++;

      // every neuron through a clamped neuron count
      run_phase(1, 127, 0);
      send_vector(1);
      // a long vector, then one past the buffer depth
      run_phase(32, 1, 0);
      send_vector(32);
      send_vector(66);
      run_phase(0, 5, 2);
      run_phase(127, 4, 2);
      run_phase(3, 0, 3);
      while (items_sent < ITEM_TARGET) begin
         run_phase($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(2, 5));
      end
      settle();
      repeat (64) @(posedge clock);

      $display("%0d transactions in %0d vectors across %0d layer settings",
               items_sent, vectors_sent, settings_used);
      $display("%0d results checked, %0d of them length errors",
               results_checked, size_errors_seen);
      if (mismatches == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
